### src/brt_pkg.sv
// ----------------------------------------------------------------------------
// brt_pkg: shared types and constants for the backward rising edge trigger
// Request and result payload layouts, register map, controller states.
// ----------------------------------------------------------------------------
package brt_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TARGET_W = 13;
  localparam int unsigned RANGE_W = 14;
  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned CROSS_W = 13;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned THR_W = 15;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd328;

  localparam int unsigned LOOKAHEAD_MIN = 4;

  // The quotient of (num << 16) / den with num <= den has 17 bits.
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 5'd16;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TARGET_W-1:0]        target_index;
    logic [RANGE_W-1:0]         search_range;
    logic [PERIOD_W-1:0]        period_samples;
  } in_req_t;

  typedef struct packed {
    logic                found;
    logic [CROSS_W-1:0]  crossing_index;
    logic [FRAC_W-1:0]   fraction_q16;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_FETCH,
    ST_SCAN,
    ST_PEAK,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### src/backward_rising_edge_trigger.sv
// ----------------------------------------------------------------------------
// backward_rising_edge_trigger
// Sample ring with a backward search for a qualified rising zero crossing.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+-----------
//  in      | in_valid_i, in_stall_o, in_req_i     | request in
//  out     | out_valid_o, out_stall_i, out_res_o  | result out
//  cfg     | psel, penable, pwrite, paddr, ...    | APB slave
//
// A store request is written to the ring in its accept cycle. A search reduces
// the target modulo RING_DEPTH by repeated subtraction, fetches the target
// sample (skipped for a zero range), walks back one position at a time, reads
// a look-ahead window for each crossing tested, runs the divider when one
// passes and loads the result; the single memory read port sets the pace.
// After reset the ring is zeroed with in_stall_o high. Stalled results are held.
// ----------------------------------------------------------------------------
module backward_rising_edge_trigger #(
  parameter int unsigned RING_DEPTH = 8192,
  parameter int unsigned LOOKAHEAD_MAX = 256
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  brt_pkg::in_req_t                       in_req_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output brt_pkg::out_res_t                      out_res_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [brt_pkg::PADDR_W-1:0]            paddr,
  input  logic [brt_pkg::PDATA_W-1:0]            pwdata,
  output logic [brt_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned LW = $clog2(LOOKAHEAD_MAX + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST_ADDR : a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [brt_pkg::SAMPLE_W-1:0] mag(
    input logic [brt_pkg::SAMPLE_W-1:0] v
  );
    return v[brt_pkg::SAMPLE_W-1] ? (~v + brt_pkg::SAMPLE_W'(1)) : v;
  endfunction

  // Sample ring
  logic [brt_pkg::SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [brt_pkg::SAMPLE_W-1:0] wr_data;
  logic [AW-1:0]                rd_addr;
  logic [brt_pkg::SAMPLE_W-1:0] rd_data_q;

  brt_pkg::state_e state_q, state_d;

  logic [AW-1:0]                wp_q;
  logic [AW-1:0]                clr_q;
  logic [brt_pkg::THR_W-1:0]    thr_q;
  logic                         out_valid_q;
  brt_pkg::out_res_t            out_res_q;

  logic [brt_pkg::TARGET_W-1:0] tgt_q;
  logic [CW-1:0]                cnt_q;
  logic [LW-1:0]                look_q;
  logic [AW-1:0]                pos_q;
  logic [AW-1:0]                pk_addr_q;
  logic [LW-1:0]                iss_q;
  logic [LW-1:0]                rcv_q;
  logic [brt_pkg::SAMPLE_W-1:0] cur_q;
  logic [brt_pkg::SAMPLE_W-1:0] prv_q;
  logic [brt_pkg::SAMPLE_W-1:0] peak_q;
  logic                         found_q;
  logic [brt_pkg::FRAC_W-1:0]   rem_q;
  logic [brt_pkg::SAMPLE_W-1:0] den_q;
  logic [brt_pkg::FRAC_W-1:0]   quo_q;
  logic [brt_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic                         first_q;

  logic                         in_accept;
  logic                         out_free;
  logic                         cfg_write;
  logic                         tgt_big;
  logic                         crossing;
  logic [AW-1:0]                prv_addr;
  logic [brt_pkg::SAMPLE_W-1:0] peak_new;
  logic                         peak_pass;
  logic [CW-1:0]                range_sat;
  logic [LW-1:0]                look_len;
  logic [31:0]                  range_w;
  logic [31:0]                  per_w;
  logic [brt_pkg::FRAC_W-1:0]   trial;
  logic                         trial_ge;
  logic [brt_pkg::SAMPLE_W-1:0] den_new;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_write = psel && penable && pwrite && pready;
  assign tgt_big = (32'(tgt_q) >= 32'(RING_DEPTH));
  assign prv_addr = addr_dec(pos_q);
  assign crossing = rd_data_q[brt_pkg::SAMPLE_W-1] && !cur_q[brt_pkg::SAMPLE_W-1];
  assign peak_new = (mag(rd_data_q) > peak_q) ? mag(rd_data_q) : peak_q;
  assign peak_pass = (peak_new > {1'b0, thr_q});
  // prv is negative and cur is not, so the difference fits in 16 bits unsigned.
  assign den_new = brt_pkg::SAMPLE_W'({1'b0, cur_q} - {prv_q[brt_pkg::SAMPLE_W-1], prv_q});
  assign trial = first_q ? rem_q : {rem_q[brt_pkg::FRAC_W-2:0], 1'b0};
  assign trial_ge = (trial >= {1'b0, den_q});

  always_comb begin
    range_w = 32'(in_req_i.search_range);
    per_w = 32'(in_req_i.period_samples >> 2);
    if (range_w > 32'(RING_DEPTH)) begin
      range_w = 32'(RING_DEPTH);
    end
    if (per_w < 32'(brt_pkg::LOOKAHEAD_MIN)) begin
      per_w = 32'(brt_pkg::LOOKAHEAD_MIN);
    end
    if (per_w > 32'(LOOKAHEAD_MAX)) begin
      per_w = 32'(LOOKAHEAD_MAX);
    end
    range_sat = CW'(range_w);
    look_len = LW'(per_w);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brt_pkg::ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = brt_pkg::ST_IDLE;
      end
      brt_pkg::ST_IDLE: begin
        if (in_accept && (in_req_i.mode == brt_pkg::MODE_SEARCH)) begin
          state_d = brt_pkg::ST_REDUCE;
        end
      end
      brt_pkg::ST_REDUCE: begin
        if (!tgt_big) begin
          state_d = (cnt_q == '0) ? brt_pkg::ST_DONE : brt_pkg::ST_FETCH;
        end
      end
      brt_pkg::ST_FETCH: state_d = brt_pkg::ST_SCAN;
      brt_pkg::ST_SCAN: begin
        if (crossing) begin
          state_d = brt_pkg::ST_PEAK;
        end else if (cnt_q == CW'(1)) begin
          state_d = brt_pkg::ST_DONE;
        end
      end
      brt_pkg::ST_PEAK: begin
        if (rcv_q == LW'(1)) begin
          if (peak_pass) begin
            state_d = brt_pkg::ST_DIV;
          end else if (cnt_q == CW'(1)) begin
            state_d = brt_pkg::ST_DONE;
          end else begin
            state_d = brt_pkg::ST_SCAN;
          end
        end
      end
      brt_pkg::ST_DIV: begin
        if (div_cnt_q == '0) state_d = brt_pkg::ST_DONE;
      end
      brt_pkg::ST_DONE: begin
        if (out_free) state_d = brt_pkg::ST_IDLE;
      end
      default: state_d = brt_pkg::ST_CLEAR;
    endcase
  end

  // Memory control and handshake outputs
  always_comb begin
    in_stall_o = (state_q != brt_pkg::ST_IDLE);
    wr_en = 1'b0;
    wr_addr = wp_q;
    wr_data = in_req_i.sample;
    rd_addr = pos_q;
    unique case (state_q)
      brt_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      brt_pkg::ST_IDLE: begin
        wr_en = in_accept && (in_req_i.mode == brt_pkg::MODE_STORE);
      end
      brt_pkg::ST_REDUCE: rd_addr = AW'(tgt_q);
      brt_pkg::ST_FETCH: rd_addr = prv_addr;
      brt_pkg::ST_SCAN: rd_addr = crossing ? pos_q : addr_dec(prv_addr);
      brt_pkg::ST_PEAK: rd_addr = (iss_q != '0) ? pk_addr_q : addr_dec(prv_addr);
      default: rd_addr = pos_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brt_pkg::ST_CLEAR;
      clr_q <= '0;
      wp_q <= '0;
      thr_q <= brt_pkg::THRESHOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == brt_pkg::ST_CLEAR) begin
        clr_q <= addr_inc(clr_q);
      end
      if (in_accept && (in_req_i.mode == brt_pkg::MODE_STORE)) begin
        wp_q <= addr_inc(wp_q);
      end
      if (cfg_write && (paddr[brt_pkg::PADDR_W-1:2] == brt_pkg::REG_THRESHOLD)) begin
        thr_q <= pwdata[brt_pkg::THR_W-1:0];
      end
      if ((state_q == brt_pkg::ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      brt_pkg::ST_IDLE: begin
        if (in_accept && (in_req_i.mode == brt_pkg::MODE_SEARCH)) begin
          tgt_q <= in_req_i.target_index;
          cnt_q <= range_sat;
          look_q <= look_len;
        end
      end
      brt_pkg::ST_REDUCE: begin
        found_q <= 1'b0;
        if (tgt_big) begin
          tgt_q <= brt_pkg::TARGET_W'(32'(tgt_q) - 32'(RING_DEPTH));
        end else begin
          pos_q <= AW'(tgt_q);
        end
      end
      brt_pkg::ST_FETCH: cur_q <= rd_data_q;
      brt_pkg::ST_SCAN: begin
        prv_q <= rd_data_q;
        if (crossing) begin
          pk_addr_q <= addr_inc(pos_q);
          iss_q <= look_q - LW'(1);
          rcv_q <= look_q;
          peak_q <= '0;
        end else begin
          // Walk one step back: the previous sample becomes the current one.
          pos_q <= prv_addr;
          cur_q <= rd_data_q;
          cnt_q <= cnt_q - CW'(1);
        end
      end
      brt_pkg::ST_PEAK: begin
        peak_q <= peak_new;
        rcv_q <= rcv_q - LW'(1);
        if (iss_q != '0) begin
          pk_addr_q <= addr_inc(pk_addr_q);
          iss_q <= iss_q - LW'(1);
        end
        if (rcv_q == LW'(1)) begin
          if (peak_pass) begin
            found_q <= 1'b1;
            rem_q <= {1'b0, mag(prv_q)};
            den_q <= den_new;
            quo_q <= '0;
            div_cnt_q <= brt_pkg::DIV_LAST_BIT;
            first_q <= 1'b1;
          end else begin
            pos_q <= prv_addr;
            cur_q <= prv_q;
            cnt_q <= cnt_q - CW'(1);
          end
        end
      end
      brt_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_q <= trial_ge ? (trial - {1'b0, den_q}) : trial;
        quo_q <= {quo_q[brt_pkg::FRAC_W-2:0], trial_ge};
        first_q <= 1'b0;
        div_cnt_q <= div_cnt_q - brt_pkg::DIV_CNT_W'(1);
      end
      brt_pkg::ST_DONE: begin
        if (out_free) begin
          out_res_q.found <= found_q;
          out_res_q.crossing_index <= found_q ? brt_pkg::CROSS_W'(prv_addr) : '0;
          out_res_q.fraction_q16 <= found_q ? quo_q : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o = out_res_q;

  assign pready = 1'b1;
  assign prdata = (paddr[brt_pkg::PADDR_W-1:2] == brt_pkg::REG_THRESHOLD) ?
                  brt_pkg::PDATA_W'(thr_q) : '0;

`ifndef SYNTHESIS
  a_no_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.found |->
      out_res_o.crossing_index == '0 && out_res_o.fraction_q16 == '0)
    else $error("empty result carries nonzero index or fraction");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.found |->
      out_res_o.fraction_q16 != '0 && out_res_o.fraction_q16 <= 17'd65536)
    else $error("crossing fraction out of range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == brt_pkg::ST_DONE)
    else $error("result raised outside of the done state");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == brt_pkg::ST_DIV |-> den_q != '0)
    else $error("divider started with a zero denominator");
`endif

endmodule
